@@ hdl/hnbs_pkg.sv @@
`default_nettype none
package hnbs_pkg;

	localparam int DATA_BITS = 8;
	localparam int BIT_IDX_W = $clog2(DATA_BITS);
	localparam int RUN_W = 3;
	localparam int STUFF_CNT_W = 2;
	localparam logic [STUFF_CNT_W-1:0] MAX_STUFF_PER_BYTE = 2'd2;
	localparam logic [RUN_W-1:0] RUN_MAX = 3'd7;

	localparam logic [RUN_W-1:0] STUFF_RUN_LIMIT_RST = 3'd5;
	localparam logic [DATA_BITS-1:0] FLAG_PATTERN_RST = 8'h7E;

	// configuration register indexes
	localparam logic CFG_STUFF_RUN_LIMIT = 1'b0;
	localparam logic CFG_FLAG_PATTERN = 1'b1;

	// one bit period on the line
	typedef struct packed {
		logic byte_done;
		logic stuffed;
		logic tone_low;
	} hnbs_beat_t;

endpackage
`default_nettype wire

@@ hdl/hnbs_serializer.sv @@
`default_nettype none
module hnbs_serializer (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              load,
	input  wire logic [hnbs_pkg::DATA_BITS-1:0]    load_byte,
	input  wire logic                              load_last,
	input  wire logic [hnbs_pkg::RUN_W-1:0]        run_limit,
	input  wire logic [hnbs_pkg::DATA_BITS-1:0]    flag_pattern,
	input  wire logic                              adv,
	output logic                                   in_ready,
	output logic                                   beat_valid,
	output hnbs_pkg::hnbs_beat_t                   beat
);
	import hnbs_pkg::*;

	logic [DATA_BITS-1:0]   shift_q;
	logic [BIT_IDX_W-1:0]   bit_idx_q;
	logic [STUFF_CNT_W-1:0] stuffs_q;
	logic [RUN_W-1:0]       run_q;
	logic                   tone_q;
	logic                   busy_q;
	logic                   is_flag_q;
	logic                   last_q;

	logic step;
	logic do_stuff;
	logic tone_next;
	logic last_step;

	assign step      = busy_q && adv;
	assign do_stuff  = (run_q >= run_limit) && (stuffs_q < MAX_STUFF_PER_BYTE);
	// NRZI: a zero, stuffed or not, flips the tone
	assign tone_next = (do_stuff || !shift_q[0]) ? ~tone_q : tone_q;
	assign last_step = step && !do_stuff && (bit_idx_q == BIT_IDX_W'(DATA_BITS - 1));

	assign in_ready   = !busy_q || last_step;
	assign beat_valid = busy_q;

	always_comb begin
		beat.tone_low  = tone_next;
		beat.stuffed   = do_stuff;
		beat.byte_done = !do_stuff && (bit_idx_q == BIT_IDX_W'(DATA_BITS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			tone_q   <= 1'b0;
			run_q    <= '0;
			stuffs_q <= '0;
			bit_idx_q <= '0;
		end else begin
			if (step) begin
				tone_q <= tone_next;
				if (do_stuff) begin
					run_q    <= '0;
					stuffs_q <= stuffs_q + 1'b1;
				end else begin
					if (!shift_q[0]) begin
						run_q <= '0;
					end else if (!is_flag_q && run_q != RUN_MAX) begin
						run_q <= run_q + 1'b1;
					end
					bit_idx_q <= bit_idx_q + 1'b1;
					if (last_step) begin
						busy_q <= 1'b0;
						// packet end: back to the high tone, run is kept
						if (last_q) begin
							tone_q <= 1'b0;
						end
					end
				end
			end
			if (load) begin
				busy_q    <= 1'b1;
				bit_idx_q <= '0;
				stuffs_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && !do_stuff) begin
			shift_q <= shift_q >> 1;
		end
		if (load) begin
			shift_q   <= load_byte;
			is_flag_q <= (load_byte == flag_pattern);
			last_q    <= load_last;
		end
	end

	a_stuff_cap: assert property (@(posedge clk) disable iff (!arst_n)
		stuffs_q <= MAX_STUFF_PER_BYTE)
		else $error("more stuffed zeros than allowed in one byte");

	a_stuff_clears_run: assert property (@(posedge clk) disable iff (!arst_n)
		(step && do_stuff) |=> (run_q == '0))
		else $error("stuffed zero did not clear the run");

	a_byte_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(last_step && !load) |=> !busy_q)
		else $error("serializer still busy after last data bit");

	a_load_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> in_ready)
		else $error("byte loaded while serializer busy");

endmodule
`default_nettype wire

@@ hdl/hnbs_out_reg.sv @@
`default_nettype none
module hnbs_out_reg (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 beat_valid,
	input  wire hnbs_pkg::hnbs_beat_t beat,
	output logic                      adv,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output hnbs_pkg::hnbs_beat_t      out_beat
);
	import hnbs_pkg::*;

	logic       valid_q;
	hnbs_beat_t beat_q;

	// take a new word whenever the slot is empty or being drained
	assign adv       = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_beat  = beat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= beat_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && beat_valid) begin
			beat_q <= beat;
		end
	end

endmodule
`default_nettype wire

@@ hdl/hdlc_nrzi_bit_stuffing_serializer_top.sv @@
`default_nettype none
// HDLC bit-stuffing serializer with NRZI tone coding.
//
// s_axis: one packet byte per word, sent least significant bit first;
//   tlast marks the last byte of a packet (tone returns high afterwards).
// m_axis: one word per bit period. tdata[0] is the tone (1 = low tone),
//   tuser flags an inserted stuffing zero, tlast marks the last bit period
//   caused by a byte.
// cfg: write-only register port, index 0 = stuff run limit (3 bits, reset 5),
//   index 1 = flag pattern (8 bits, reset 0x7E). Write only while idle.
//
// Throughput: a byte yields its 8 data bits plus up to 2 stuffed zeros,
// one bit period per cycle while m_axis_tready does not stall; the next
// byte is taken in the cycle the last data bit leaves the serializer.
// Path: an accepted byte is loaded into the serializer's shift register,
// and each bit period then passes through the output register to m_axis.
// Reset: tone goes to high, run of ones cleared, registers to defaults.
// Stall: a low m_axis_tready holds the output word and freezes the
// serializer; s_axis_tready drops until the current byte has drained.
module hdlc_nrzi_bit_stuffing_serializer_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  wire logic       s_axis_tlast,   // packet_end
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // [0] tone_low, [7:1] zero
	output logic            m_axis_tuser,   // stuffed
	output logic            m_axis_tlast,   // byte_done
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data
);
	import hnbs_pkg::*;

	logic [RUN_W-1:0]     run_limit_q;
	logic [DATA_BITS-1:0] flag_pattern_q;

	logic       load;
	logic       in_ready;
	logic       adv;
	logic       beat_valid;
	hnbs_beat_t beat;
	hnbs_beat_t out_beat;

	// config writes always land at once
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_limit_q    <= STUFF_RUN_LIMIT_RST;
			flag_pattern_q <= FLAG_PATTERN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_STUFF_RUN_LIMIT: run_limit_q    <= cfg_data[RUN_W-1:0];
				CFG_FLAG_PATTERN:    flag_pattern_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_axis_tready = in_ready;
	assign load          = s_axis_tvalid && in_ready;

	hnbs_serializer u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.load_byte    (s_axis_tdata),
		.load_last    (s_axis_tlast),
		.run_limit    (run_limit_q),
		.flag_pattern (flag_pattern_q),
		.adv          (adv),
		.in_ready     (in_ready),
		.beat_valid   (beat_valid),
		.beat         (beat)
	);

	hnbs_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.beat_valid (beat_valid),
		.beat       (beat),
		.adv        (adv),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_beat   (out_beat)
	);

	assign m_axis_tdata = {7'b0, out_beat.tone_low};
	assign m_axis_tuser = out_beat.stuffed;
	assign m_axis_tlast = out_beat.byte_done;

endmodule
`default_nettype wire

@@ sim/hnbs_line_checker.sv @@
`timescale 1ns / 100ps
module hnbs_line_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	input  wire logic       s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  wire logic       s_axis_tlast,   // packet_end
	input  wire logic       m_axis_tvalid,
	input  wire logic       m_axis_tready,
	input  wire logic [7:0] m_axis_tdata,   // [0] tone_low, [7:1] zero
	input  wire logic       m_axis_tuser,   // stuffed
	input  wire logic       m_axis_tlast,   // byte_done
	input  wire logic       cfg_valid,
	input  wire logic       cfg_ready,
	input  wire logic       cfg_index,
	input  wire logic [7:0] cfg_data,
	output int              errors,
	output int              pending,
	output int              periods,
	output int              stuff_periods
);
	import hnbs_pkg::*;

	// line state and register copies kept alongside the block
	logic                 tone_lvl;
	logic [RUN_W-1:0]     run_cnt;
	logic [RUN_W-1:0]     stuff_limit;
	logic [DATA_BITS-1:0] flag_byte;

	hnbs_beat_t line_q[$];
	hnbs_beat_t want;

	initial begin
		errors = 0;
		pending = 0;
		periods = 0;
		stuff_periods = 0;
	end

	// Expand one byte into its bit periods, LSB first, with stuffing and NRZI.
	function automatic void predict_byte(input logic [7:0] data, input logic pkt_end);
		int         bit_i;
		int         n_stuff;
		logic       is_flag;
		hnbs_beat_t beat;
		bit_i = 0;
		n_stuff = 0;
		is_flag = (data == flag_byte);
		while (bit_i < DATA_BITS) begin
			if (run_cnt >= stuff_limit && n_stuff < int'(MAX_STUFF_PER_BYTE)) begin
				tone_lvl = ~tone_lvl;
				run_cnt = '0;
				n_stuff++;
				beat.tone_low = tone_lvl;
				beat.stuffed = 1'b1;
				beat.byte_done = 1'b0;
				line_q.push_back(beat);
			end else begin
				if (!data[bit_i]) begin
					tone_lvl = ~tone_lvl;
					run_cnt = '0;
				end else if (!is_flag && run_cnt != RUN_MAX) begin
					run_cnt = run_cnt + 1'b1;
				end
				beat.tone_low = tone_lvl;
				beat.stuffed = 1'b0;
				beat.byte_done = 1'b0;
				line_q.push_back(beat);
				bit_i++;
			end
		end
		// mark the closing period of the byte
		beat = line_q.pop_back();
		beat.byte_done = 1'b1;
		line_q.push_back(beat);
		if (pkt_end)
			tone_lvl = 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_lvl = 1'b0;
			run_cnt = '0;
			stuff_limit = STUFF_RUN_LIMIT_RST;
			flag_byte = FLAG_PATTERN_RST;
			line_q.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_STUFF_RUN_LIMIT)
					stuff_limit = cfg_data[RUN_W-1:0];
				else
					flag_byte = cfg_data;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (line_q.size() == 0) begin
					$error("unexpected bit period: tone_low %0d stuffed %0d byte_done %0d",
						m_axis_tdata[0], m_axis_tuser, m_axis_tlast);
					errors++;
				end else begin
					want = line_q.pop_front();
					if (m_axis_tdata[0] !== want.tone_low) begin
						$error("tone_low mismatch: expected %0d, got %0d",
							want.tone_low, m_axis_tdata[0]);
						errors++;
					end
					if (m_axis_tuser !== want.stuffed) begin
						$error("stuffed mismatch: expected %0d, got %0d",
							want.stuffed, m_axis_tuser);
						errors++;
					end
					if (m_axis_tlast !== want.byte_done) begin
						$error("byte_done mismatch: expected %0d, got %0d",
							want.byte_done, m_axis_tlast);
						errors++;
					end
					if (m_axis_tdata[7:1] !== 7'd0) begin
						$error("tdata padding mismatch: expected 0, got %0h",
							m_axis_tdata[7:1]);
						errors++;
					end
				end
				periods++;
				if (m_axis_tuser)
					stuff_periods++;
			end
			if (s_axis_tvalid && s_axis_tready)
				predict_byte(s_axis_tdata, s_axis_tlast);
			pending = line_q.size();
		end
	end

endmodule

@@ sim/hdlc_nrzi_bit_stuffing_serializer_top_tb.sv @@
`timescale 1ns / 100ps
module hdlc_nrzi_bit_stuffing_serializer_top_tb;
	import hnbs_pkg::*;

	// no word accepted on any channel for this long means the block is stuck
	localparam int IDLE_LIMIT = 3000;
	// long output hold-off that backs the serializer up into its input
	localparam int HOLD_CYCLES = 300;
	// cycles to let the pipeline settle after the last expected period
	localparam int SETTLE = 8;
	localparam int PHASES = 6;
	localparam int BYTES_PER_PHASE = 27;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'd0;
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tuser;
	logic       m_axis_tlast;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_index = CFG_STUFF_RUN_LIMIT;
	logic [7:0] cfg_data = 8'd0;

	int errors;
	int pending;
	int periods;
	int stuff_periods;

	// stimulus bookkeeping
	bit         quiet_tx = 1'b0;   // sender offers words back to back
	bit         quiet_rx = 1'b0;   // receiver never stalls
	bit         hold_rx = 1'b0;    // request a long receiver hold-off
	int         holds_done = 0;
	int         bytes_sent = 0;
	int         packets_sent = 0;
	int         reg_writes = 0;
	int         idle_cycles = 0;
	logic [7:0] flag_now = FLAG_PATTERN_RST;

	hdlc_nrzi_bit_stuffing_serializer_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	hnbs_line_checker i_line_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.pending       (pending),
		.periods       (periods),
		.stuff_periods (stuff_periods)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Watchdog: count cycles with no handshake on any channel.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Receiver: stall a random number of cycles before each word, or hold off
	// for a long stretch when asked. Keep tready high across words with no stall.
	initial begin : rx_proc
		int stall;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_rx) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx = 1'b0;
				holds_done++;
			end
			stall = quiet_rx ? 0 : $urandom_range(0, 16);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Offer one byte after a random gap; hold it until the block takes it.
	// Leave tvalid high on return so a zero gap streams the next byte directly.
	task automatic send_byte(input logic [7:0] data, input logic pkt_end);
		int gap;
		gap = quiet_tx ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		s_axis_tlast <= pkt_end;
		do @(posedge clk); while (!s_axis_tready);
		bytes_sent++;
		if (pkt_end)
			packets_sent++;
	endtask

	// Drop tvalid and wait until every expected bit period has come out,
	// then let the pipeline settle so the block is truly idle.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// One register write; drop valid and let a clock edge pass so back-to-back
	// writes never lower and raise valid in the same step.
	task automatic write_reg(input logic idx, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		reg_writes++;
	endtask

	// Write the run limit with random junk in the unused upper bits.
	task automatic set_limit(input logic [RUN_W-1:0] lim);
		logic [7-RUN_W:0] junk;
		junk = (8-RUN_W)'($urandom_range(0, 31));
		write_reg(CFG_STUFF_RUN_LIMIT, {junk, lim});
	endtask

	task automatic set_flag(input logic [7:0] pattern);
		write_reg(CFG_FLAG_PATTERN, pattern);
		flag_now = pattern;
	endtask

	// Bias bytes toward long runs of ones and the flag so stuffing is frequent.
	function automatic logic [7:0] pick_byte();
		logic [7:0] b;
		case ($urandom_range(0, 6))
			0: b = 8'hFF;
			1: b = flag_now;
			2: b = 8'($urandom_range(0, 255) | $urandom_range(0, 255));
			3: b = ~(8'd1 << $urandom_range(0, 7));
			4: b = 8'($urandom_range(0, 255) & $urandom_range(0, 255));
			default: b = 8'($urandom_range(0, 255));
		endcase
		return b;
	endfunction

	task automatic send_packet(input int len);
		for (int i = 0; i < len; i++)
			send_byte(pick_byte(), i == len - 1);
	endtask

	initial begin : main_proc
		logic [RUN_W-1:0] phase_limit[PHASES];
		int               phase_bytes;
		phase_limit = '{3'd5, 3'd2, 3'd7, 3'd3, 3'd0, 3'd1};
		phase_limit[5] = RUN_W'($urandom_range(0, 7));

		// hold reset, then release it at a clock edge
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset values: all zeros, all ones, the flag, a run that
		// completes on the last bit and closes a packet, so the stuffed zero
		// opens the next packet.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(FLAG_PATTERN_RST, 1'b0);
		send_byte(8'hF8, 1'b1);
		send_byte(8'hAA, 1'b0);
		send_byte(8'hFF, 1'b1);

		// limit 1: more stuffs wanted than a byte allows, run reaches its top value
		drain();
		set_limit(3'd1);
		send_byte(8'hFF, 1'b0);
		send_byte(FLAG_PATTERN_RST, 1'b0);
		send_byte(8'hFF, 1'b1);

		// limit 0: every byte opens with two stuffed zeros
		drain();
		set_limit(3'd0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);

		// top limit with an all-ones flag
		drain();
		set_limit(3'd7);
		set_flag(8'hFF);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFE, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h80, 1'b1);

		// all-zeros flag
		drain();
		set_flag(8'h00);
		send_byte(8'h00, 1'b0);
		send_byte(8'h01, 1'b1);

		// Random phases, each with its own register setting.
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			set_limit(phase_limit[ph]);
			if (ph == 0)
				set_flag(FLAG_PATTERN_RST);
			else if (ph == 2)
				set_flag(8'hFF);
			else
				set_flag(8'($urandom_range(0, 255)));
			// phase 1 runs with no idling on either side
			quiet_tx = (ph == 1);
			quiet_rx = (ph == 1);
			if (ph == 3) begin
				// back the block up: receiver holds off, sender streams
				hold_rx = 1'b1;
				quiet_tx = 1'b1;
			end
			phase_bytes = bytes_sent;
			while (bytes_sent - phase_bytes < BYTES_PER_PHASE)
				send_packet($urandom_range(1, 6));
			if (ph == 3) begin
				// pause until every expected period has come out
				quiet_tx = 1'b0;
				drain();
			end
		end

		quiet_tx = 1'b0;
		quiet_rx = 1'b0;
		drain();

		$display("Run: %0d bytes in %0d packets, %0d register writes, %0d long hold-offs.",
			bytes_sent, packets_sent, reg_writes, holds_done);
		$display("Checked %0d bit periods, %0d of them stuffed zeros.",
			periods, stuff_periods);
		if (errors == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
